/* src/websocket_frame_deframer_top_defines.svh */
// ----------------------------------------------------------------------------
// WebSocket frame deframer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication.
`define WSFD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/wsfd_pkg.sv */
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Parse phases, event codes, status codes and the result record.
// ----------------------------------------------------------------------------
package wsfd_pkg;

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;

    localparam logic [2:0] EV_MSG   = 3'd0;
    localparam logic [2:0] EV_PING  = 3'd1;
    localparam logic [2:0] EV_PONG  = 3'd2;
    localparam logic [2:0] EV_CLOSE = 3'd3;
    localparam logic [2:0] EV_ERROR = 3'd4;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [15:0] CODE_NORMAL    = 16'd1000;
    localparam logic [15:0] CODE_PROTOCOL  = 16'd1002;
    localparam logic [15:0] CODE_TOO_LARGE = 16'd1009;

    localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

    typedef struct packed {
        logic [2:0]  ev;
        logic [7:0]  data;
        logic        bvalid;
        logic [1:0]  mop;
        logic        frag;
        logic        last;
        logic [15:0] code;
    } wsfd_result_t;

endpackage

/* src/wsfd_parser.sv */
// ----------------------------------------------------------------------------
// WebSocket frame parser core
// Holds the header and payload state; one byte is parsed per accepted cycle.
// ----------------------------------------------------------------------------
module wsfd_parser
    import wsfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_accept,
    input  logic [7:0]   rx_byte,
    input  logic [31:0]  max_payload_len,
    output logic         res_valid,
    output wsfd_result_t res
);

    logic [2:0]  phase_reg,  phase_next;
    logic        fin_reg,    fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic [63:0] len_reg,    len_next;
    logic [3:0]  hcount_reg, hcount_next;
    logic [31:0] key_reg,    key_next;
    logic [31:0] pos_reg,    pos_next;
    logic [1:0]  fragop_reg, fragop_next;
    logic [15:0] cstat_reg,  cstat_next;
    logic        halted_reg, halted_next;

    logic        ld_go;
    logic        hd_go;
    logic        data_op;
    logic        valid_op;
    logic [7:0]  key_byte;
    logic [7:0]  ub;
    logic        final_byte;
    logic        whole;
    logic        msg_last;
    logic [15:0] cstat_low;

    always_comb
    begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        len_next    = len_reg;
        hcount_next = hcount_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        fragop_next = fragop_reg;
        cstat_next  = cstat_reg;
        halted_next = halted_reg;
        res_valid   = 1'b0;
        res         = '0;
        ld_go       = 1'b0;
        hd_go       = 1'b0;

        data_op  = (opcode_reg == OP_TEXT) || (opcode_reg == OP_BINARY);
        valid_op = data_op || (opcode_reg == OP_CONT) || (opcode_reg == OP_CLOSE) ||
                   (opcode_reg == OP_PING) || (opcode_reg == OP_PONG);

        case (pos_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
        ub         = masked_reg ? (rx_byte ^ key_byte) : rx_byte;
        final_byte = (({1'b0, pos_reg} + 33'd1) == len_reg[32:0]) && (len_reg[63:33] == '0);
        whole      = fin_reg && (opcode_reg != OP_CONT);
        msg_last   = fin_reg && final_byte;
        cstat_low  = {cstat_reg[15:8], ub};

        if (byte_accept && !halted_reg)
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    fin_next    = rx_byte[7];
                    opcode_next = rx_byte[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    masked_next = rx_byte[7];
                    if (rx_byte[6:0] == LEN_EXT16 || rx_byte[6:0] == LEN_EXT64)
                    begin
                        hcount_next = (rx_byte[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
                        len_next    = '0;
                        phase_next  = PH_EXT;
                    end
                    else
                    begin
                        len_next = {57'd0, rx_byte[6:0]};
                        ld_go    = 1'b1;
                    end
                end
                PH_EXT:
                begin
                    len_next    = {len_reg[55:0], rx_byte};
                    hcount_next = hcount_reg - 4'd1;
                    ld_go       = (hcount_reg == 4'd1);
                end
                PH_KEY:
                begin
                    key_next    = {key_reg[23:0], rx_byte};
                    hcount_next = hcount_reg - 4'd1;
                    hd_go       = (hcount_reg == 4'd1);
                end
                PH_DATA:
                begin
                    pos_next = pos_reg + 32'd1;
                    if (final_byte)
                        phase_next = PH_HDR0;
                    if (opcode_reg == OP_CLOSE)
                    begin
                        if (pos_reg == 32'd0)
                        begin
                            if (final_byte)
                            begin
                                halted_next = 1'b1;
                                res_valid   = 1'b1;
                                res.ev      = EV_CLOSE;
                                res.last    = 1'b1;
                                res.code    = CODE_NORMAL;
                            end
                            else
                                cstat_next = {ub, 8'h00};
                        end
                        else if (pos_reg == 32'd1)
                        begin
                            cstat_next = cstat_low;
                            if (final_byte)
                            begin
                                halted_next = 1'b1;
                                res_valid   = 1'b1;
                                res.ev      = EV_CLOSE;
                                res.last    = 1'b1;
                                res.code    = cstat_low;
                            end
                        end
                        else
                        begin
                            if (final_byte)
                                halted_next = 1'b1;
                            res_valid  = 1'b1;
                            res.ev     = EV_CLOSE;
                            res.data   = ub;
                            res.bvalid = 1'b1;
                            res.last   = final_byte;
                            res.code   = final_byte ? cstat_reg : 16'd0;
                        end
                    end
                    else if (opcode_reg == OP_PING || opcode_reg == OP_PONG)
                    begin
                        res_valid  = 1'b1;
                        res.ev     = {1'b0, opcode_reg[1:0]};
                        res.data   = ub;
                        res.bvalid = 1'b1;
                        res.last   = final_byte;
                    end
                    else
                    begin
                        if (msg_last && opcode_reg == OP_CONT)
                            fragop_next = 2'd0;
                        res_valid  = 1'b1;
                        res.ev     = EV_MSG;
                        res.data   = ub;
                        res.bvalid = 1'b1;
                        res.mop    = whole ? opcode_reg[1:0] : fragop_reg;
                        res.frag   = !whole;
                        res.last   = msg_last;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase

            // Length complete: limit check, then the mask key or the header end.
            if (ld_go)
            begin
                if ((len_next[63:32] != '0) || (len_next[31:0] > max_payload_len))
                begin
                    halted_next = 1'b1;
                    phase_next  = PH_HDR0;
                    res_valid   = 1'b1;
                    res.ev      = EV_ERROR;
                    res.last    = 1'b1;
                    res.code    = CODE_TOO_LARGE;
                end
                else if (masked_next)
                begin
                    phase_next  = PH_KEY;
                    hcount_next = 4'd4;
                    key_next    = '0;
                end
                else
                    hd_go = 1'b1;
            end

            if (hd_go)
            begin
                if (!valid_op)
                begin
                    halted_next = 1'b1;
                    phase_next  = PH_HDR0;
                    res_valid   = 1'b1;
                    res.ev      = EV_ERROR;
                    res.last    = 1'b1;
                    res.code    = CODE_PROTOCOL;
                end
                else
                begin
                    if (data_op && !fin_reg && fragop_reg == 2'd0)
                        fragop_next = opcode_reg[1:0];
                    cstat_next = CODE_NORMAL;
                    pos_next   = '0;
                    if (len_next != '0)
                        phase_next = PH_DATA;
                    else
                    begin
                        phase_next = PH_HDR0;
                        if (opcode_reg == OP_CLOSE)
                        begin
                            halted_next = 1'b1;
                            res_valid   = 1'b1;
                            res.ev      = EV_CLOSE;
                            res.last    = 1'b1;
                            res.code    = CODE_NORMAL;
                        end
                        else if (opcode_reg == OP_PING || opcode_reg == OP_PONG)
                        begin
                            res_valid = 1'b1;
                            res.ev    = {1'b0, opcode_reg[1:0]};
                            res.last  = 1'b1;
                        end
                        else if (fin_reg && data_op)
                        begin
                            res_valid = 1'b1;
                            res.ev    = EV_MSG;
                            res.mop   = opcode_reg[1:0];
                            res.last  = 1'b1;
                        end
                        else if (fin_reg)
                        begin
                            // Final continuation with no payload ends the message.
                            fragop_next = 2'd0;
                            res_valid   = 1'b1;
                            res.ev      = EV_MSG;
                            res.mop     = fragop_reg;
                            res.frag    = 1'b1;
                            res.last    = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            fin_reg    <= 1'b0;
            opcode_reg <= '0;
            masked_reg <= 1'b0;
            len_reg    <= '0;
            hcount_reg <= '0;
            key_reg    <= '0;
            pos_reg    <= '0;
            fragop_reg <= '0;
            cstat_reg  <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            masked_reg <= masked_next;
            len_reg    <= len_next;
            hcount_reg <= hcount_next;
            key_reg    <= key_next;
            pos_reg    <= pos_next;
            fragop_reg <= fragop_next;
            cstat_reg  <= cstat_next;
            halted_reg <= halted_next;
        end
    end

endmodule

/* src/websocket_frame_deframer_top.sv */
// ----------------------------------------------------------------------------
// WebSocket frame deframer top level
// Parses RFC 6455 frames from a byte stream and streams out unmasked payload.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock cycle and gives at most one result
// per byte, registered into a two-entry output buffer (output register plus
// skid register). Header parsing, the length limit check and unmasking all
// complete in the cycle the byte is accepted, so throughput is one byte per
// cycle as long as results are taken; in_stall rises only when both entries
// are full. max_payload_len is written through the APB port with paddr[2] low;
// the user must do so only while the stream is idle (not enforced by the block).
// After a close frame or a protocol error every byte is dropped until reset.
`include "websocket_frame_deframer_top_defines.svh"

module websocket_frame_deframer_top
    import wsfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   rx_byte,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [2:0]   event_res,
    output logic [7:0]   data_byte,
    output logic         byte_valid,
    output logic [1:0]   msg_opcode,
    output logic         fragmented,
    output logic         last,
    output logic [15:0]  close_code
);

    logic [31:0]  max_len_reg;
    logic         in_accept;
    logic         res_valid;
    wsfd_result_t res;

    logic         out_valid_reg,  out_valid_next;
    wsfd_result_t out_data_reg,   out_data_next;
    logic         skid_valid_reg, skid_valid_next;
    wsfd_result_t skid_data_reg,  skid_data_next;
    logic         out_free;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : max_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (psel && penable && pwrite && !paddr[2])
            max_len_reg <= pwdata;
    end

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;

    wsfd_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_accept     (in_accept),
        .rx_byte         (rx_byte),
        .max_payload_len (max_len_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    // The output slot is free after this edge if empty or being taken now.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (res_valid)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
            else
                out_valid_next = 1'b0;
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign event_res  = out_data_reg.ev;
    assign data_byte  = out_data_reg.data;
    assign byte_valid = out_data_reg.bvalid;
    assign msg_opcode = out_data_reg.mop;
    assign fragmented = out_data_reg.frag;
    assign last       = out_data_reg.last;
    assign close_code = out_data_reg.code;

    `WSFD_ASSERT_SAME(a_skid_needs_out, skid_valid_reg, out_valid_reg,
        "skid entry held while output register is empty")
    `WSFD_ASSERT_NEXT(a_skid_drains, skid_valid_reg && !out_stall,
        out_valid_reg && !skid_valid_reg, "skid entry not moved to output")
    `WSFD_ASSERT_SAME(a_error_code, res_valid && (res.ev == EV_ERROR),
        res.last && !res.bvalid &&
        ((res.code == CODE_PROTOCOL) || (res.code == CODE_TOO_LARGE)),
        "error result without last or with an unknown code")

endmodule

/* dv/tb_websocket_frame_deframer_top.sv */
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Sends framed byte streams into the deframer under random idling and stalls,
// predicts every result from a built-in frame parser, and checks each result
// field by field. The length limit is changed between phases over the APB port.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer_top
    import wsfd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]  MAX_LEN_ADDR = 3'd0;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_AT      = 300;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned BODY_CAP     = 4096;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic [1:0]  msg_opcode;
    logic        fragmented;
    logic        last;
    logic [15:0] close_code;

    websocket_frame_deframer_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_res  (event_res),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .msg_opcode (msg_opcode),
        .fragmented (fragmented),
        .last       (last),
        .close_code (close_code)
    );

    always #10 clk = ~clk;

    // Stream bytes waiting to be sent, and the results the parser predicts.
    logic [7:0]   stream_q[$];
    wsfd_result_t frame_events_q[$];

    // Parser state.
    logic [2:0]  p_phase    = PH_HDR0;
    logic        p_fin      = 1'b0;
    logic [3:0]  p_opcode   = OP_CONT;
    logic        p_masked   = 1'b0;
    logic [63:0] p_len      = '0;
    logic [3:0]  p_hdr_left = '0;
    logic [31:0] p_key      = '0;
    logic [31:0] p_pos      = '0;
    logic [1:0]  p_frag_op  = '0;
    logic [15:0] p_status   = '0;
    logic        p_halted   = 1'b0;
    logic [31:0] p_max_len  = MAX_LEN_RESET;

    int unsigned n_pushed   = 0;
    int unsigned n_in_acc   = 0;
    int unsigned n_results  = 0;
    int unsigned n_frames   = 0;
    int unsigned n_settings = 0;
    int unsigned n_err      = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned send_gap   = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;
    logic        hold_done  = 1'b0;
    logic        in_taken   = 1'b0;
    logic        quiet      = 1'b0;
    string       end_case   = "";

    task automatic report_mismatch(input string msg);
        if (n_err < 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
        n_err++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s is %0d, expected %0d",
                                      n_results, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Frame parser
    // ------------------------------------------------------------------
    function automatic logic known_opcode(input logic [3:0] opc);
        return opc == OP_CONT || opc == OP_TEXT || opc == OP_BINARY ||
               opc == OP_CLOSE || opc == OP_PING || opc == OP_PONG;
    endfunction

    function automatic void push_event(input logic [2:0] ev, input logic [7:0] d,
                                       input logic bv, input logic [1:0] mop,
                                       input logic frag, input logic lst,
                                       input logic [15:0] code);
        wsfd_result_t r;
        r.ev     = ev;
        r.data   = d;
        r.bvalid = bv;
        r.mop    = mop;
        r.frag   = frag;
        r.last   = lst;
        r.code   = code;
        frame_events_q.push_back(r);
    endfunction

    function automatic void protocol_error(input logic [15:0] code);
        p_halted = 1'b1;
        p_phase  = PH_HDR0;
        push_event(EV_ERROR, 8'd0, 1'b0, 2'd0, 1'b0, 1'b1, code);
    endfunction

    function automatic void header_complete();
        logic data_op;
        data_op = (p_opcode == OP_TEXT) || (p_opcode == OP_BINARY);
        if (!known_opcode(p_opcode)) begin
            protocol_error(CODE_PROTOCOL);
            return;
        end
        if (data_op && !p_fin && p_frag_op == 2'd0)
            p_frag_op = p_opcode[1:0];
        p_status = CODE_NORMAL;
        p_pos    = '0;
        if (p_len != 64'd0) begin
            p_phase = PH_DATA;
            return;
        end
        // Zero-length frame: the whole frame resolves at the end of its header.
        p_phase = PH_HDR0;
        if (p_opcode == OP_CLOSE) begin
            p_halted = 1'b1;
            push_event(EV_CLOSE, 8'd0, 1'b0, 2'd0, 1'b0, 1'b1, CODE_NORMAL);
        end else if (p_opcode == OP_PING || p_opcode == OP_PONG) begin
            push_event(p_opcode == OP_PING ? EV_PING : EV_PONG, 8'd0, 1'b0, 2'd0,
                       1'b0, 1'b1, 16'd0);
        end else if (p_fin) begin
            if (data_op) begin
                push_event(EV_MSG, 8'd0, 1'b0, p_opcode[1:0], 1'b0, 1'b1, 16'd0);
            end else begin
                push_event(EV_MSG, 8'd0, 1'b0, p_frag_op, 1'b1, 1'b1, 16'd0);
                p_frag_op = 2'd0;
            end
        end
    endfunction

    function automatic void length_complete();
        if (p_len > {32'd0, p_max_len}) begin
            protocol_error(CODE_TOO_LARGE);
        end else if (p_masked) begin
            p_phase    = PH_KEY;
            p_hdr_left = 4'd4;
            p_key      = '0;
        end else begin
            header_complete();
        end
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        logic [31:0] pos;
        logic [7:0]  ub;
        logic        eof;
        logic        whole;
        logic        lst;
        logic [1:0]  mop;
        if (p_halted)
            return;
        case (p_phase)
            PH_HDR0: begin
                p_fin    = b[7];
                p_opcode = b[3:0];
                p_phase  = PH_HDR1;
            end
            PH_HDR1: begin
                p_masked = b[7];
                p_len    = {57'd0, b[6:0]};
                if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
                    p_hdr_left = (b[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
                    p_len      = '0;
                    p_phase    = PH_EXT;
                end else begin
                    length_complete();
                end
            end
            PH_EXT: begin
                p_len      = {p_len[55:0], b};
                p_hdr_left = p_hdr_left - 4'd1;
                if (p_hdr_left == 4'd0)
                    length_complete();
            end
            PH_KEY: begin
                p_key      = {p_key[23:0], b};
                p_hdr_left = p_hdr_left - 4'd1;
                if (p_hdr_left == 4'd0)
                    header_complete();
            end
            PH_DATA: begin
                pos = p_pos;
                ub  = b;
                if (p_masked)
                    ub = b ^ p_key[8 * (3 - pos[1:0]) +: 8];
                eof   = ({32'd0, pos} + 64'd1) == p_len;
                p_pos = pos + 32'd1;
                if (eof)
                    p_phase = PH_HDR0;
                if (p_opcode == OP_CLOSE) begin
                    // The first two bytes carry the status code and are not emitted.
                    if (pos == 32'd0) begin
                        if (eof) begin
                            p_halted = 1'b1;
                            push_event(EV_CLOSE, 8'd0, 1'b0, 2'd0, 1'b0, 1'b1,
                                       CODE_NORMAL);
                        end else begin
                            p_status = {ub, 8'd0};
                        end
                    end else if (pos == 32'd1) begin
                        p_status = p_status | {8'd0, ub};
                        if (eof) begin
                            p_halted = 1'b1;
                            push_event(EV_CLOSE, 8'd0, 1'b0, 2'd0, 1'b0, 1'b1, p_status);
                        end
                    end else begin
                        if (eof)
                            p_halted = 1'b1;
                        push_event(EV_CLOSE, ub, 1'b1, 2'd0, 1'b0, eof,
                                   eof ? p_status : 16'd0);
                    end
                end else if (p_opcode == OP_PING || p_opcode == OP_PONG) begin
                    push_event(p_opcode == OP_PING ? EV_PING : EV_PONG, ub, 1'b1, 2'd0,
                               1'b0, eof, 16'd0);
                end else begin
                    whole = p_fin && (p_opcode != OP_CONT);
                    mop   = whole ? p_opcode[1:0] : p_frag_op;
                    lst   = p_fin && eof;
                    if (lst && p_opcode == OP_CONT)
                        p_frag_op = 2'd0;
                    push_event(EV_MSG, ub, 1'b1, mop, !whole, lst, 16'd0);
                end
            end
            default: p_phase = PH_HDR0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender, receiver stall and monitor
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!in_valid || in_taken) begin
            if (send_gap > 0) begin
                in_valid <= 1'b0;
                send_gap--;
            end else if (stream_q.size() != 0) begin
                in_valid <= 1'b1;
                rx_byte  <= stream_q.pop_front();
                if (!quiet && $urandom_range(0, 11) == 0)
                    send_gap = $urandom_range(1, 13);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // The long hold-off lets the output buffer fill so that in_stall rises.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (!hold_done && n_in_acc >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 13);
        end
    end

    always @(posedge clk) begin
        wsfd_result_t want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_cnt, frame_events_q.size());
            $display("TEST FAILED");
            $finish;
        end else begin
            in_taken <= in_valid && !in_stall;
            if (rst_n && in_valid && !in_stall) begin
                n_in_acc++;
                deframe_byte(rx_byte);
            end
            if (rst_n && out_valid && !out_stall) begin
                if (frame_events_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, event_res %0d",
                                              event_res));
                end else begin
                    want = frame_events_q.pop_front();
                    check_field("event_res", event_res, want.ev);
                    check_field("data_byte", data_byte, want.data);
                    check_field("byte_valid", byte_valid, want.bvalid);
                    check_field("msg_opcode", msg_opcode, want.mop);
                    check_field("fragmented", fragmented, want.frag);
                    check_field("last", last, want.last);
                    check_field("close_code", close_code, want.code);
                end
                n_results++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic reg_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MAX_LEN_ADDR;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_max_len(input logic wr, input logic [31:0] value);
        logic [31:0] rd;
        if (wr) begin
            reg_access(1'b1, value, rd);
            p_max_len = value;
            n_settings++;
        end
        reg_access(1'b0, '0, rd);
        if (rd !== p_max_len)
            report_mismatch($sformatf("max_payload_len reads %0d, expected %0d",
                                      rd, p_max_len));
        @(posedge clk);
    endtask

    // Waits until every byte is taken and every result has arrived, then a few
    // more cycles in case a header byte is still in flight.
    task automatic wait_drained();
        do @(negedge clk); while (n_in_acc != n_pushed || frame_events_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        stream_q.push_back(b);
        n_pushed++;
    endtask

    // form: 0 short length where it fits, 1 at least 16-bit, 2 64-bit length.
    task automatic put_frame(input logic fin, input logic [3:0] opc, input logic msk,
                             input logic [63:0] len, input int form);
        logic [2:0] rsv;
        rsv = 3'($urandom_range(0, 7));
        push_byte({fin, rsv, opc});
        if (form == 0 && len <= 64'd125) begin
            push_byte({msk, len[6:0]});
        end else if (form <= 1 && len <= 64'd65535) begin
            push_byte({msk, LEN_EXT16});
            push_byte(len[15:8]);
            push_byte(len[7:0]);
        end else begin
            push_byte({msk, LEN_EXT64});
            for (int i = 7; i >= 0; i--)
                push_byte(len[8 * i +: 8]);
        end
        if (msk)
            repeat (4) push_byte(8'($urandom_range(0, 255)));
        if (len <= BODY_CAP)
            repeat (int'(len)) push_byte(8'($urandom_range(0, 255)));
        n_frames++;
    endtask

    function automatic logic [63:0] frame_len();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        if (r < 15)
            n = 0;
        else if (r < 70)
            n = $urandom_range(1, 16);
        else if (r < 88)
            n = $urandom_range(17, 125);
        else if (r < 97)
            n = $urandom_range(126, 300);
        else
            n = p_max_len;
        if (n > p_max_len)
            n = p_max_len;
        if (n > 1000)
            n = $urandom_range(1, 8);
        return 64'(n);
    endfunction

    task automatic rand_frame(input logic fin, input logic [3:0] opc);
        int form;
        form = ($urandom_range(0, 9) < 7) ? 0 : ($urandom_range(0, 2) == 0 ? 2 : 1);
        put_frame(fin, opc, 1'($urandom_range(0, 1)), frame_len(), form);
    endtask

    // Half are complete fragmented messages with control and whole messages
    // mixed in; the rest are whole, control, stray continuation and open starts.
    task automatic random_traffic(input int unsigned n_bytes);
        int unsigned stop_at;
        int unsigned kind;
        logic [3:0]  opc;
        stop_at = n_pushed + n_bytes;
        while (n_pushed < stop_at) begin
            kind = $urandom_range(0, 99);
            opc  = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
            if (kind < 50) begin
                rand_frame(1'b0, opc);
                repeat ($urandom_range(0, 3)) begin
                    if ($urandom_range(0, 3) == 0)
                        rand_frame(1'($urandom_range(0, 1)),
                                   $urandom_range(0, 1) ? OP_PING : OP_PONG);
                    else if ($urandom_range(0, 5) == 0)
                        rand_frame(1'b1, $urandom_range(0, 1) ? OP_TEXT : OP_BINARY);
                    rand_frame(1'b0, OP_CONT);
                end
                rand_frame(1'b1, OP_CONT);
            end else if (kind < 72) begin
                rand_frame(1'b1, opc);
            end else if (kind < 90) begin
                rand_frame(1'($urandom_range(0, 1)),
                           $urandom_range(0, 1) ? OP_PING : OP_PONG);
            end else if (kind < 95) begin
                rand_frame(1'($urandom_range(0, 1)), OP_CONT);
            end else begin
                rand_frame(1'b0, opc);
            end
        end
    endtask

    initial begin
        int unsigned pick;
        logic [3:0]  opc;
        logic [63:0] big_len;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        apply_max_len(1'b0, '0);

        // Directed frames under the reset limit.
        put_frame(1'b1, OP_TEXT,   1'b0, 64'd1,   0);
        put_frame(1'b1, OP_BINARY, 1'b1, 64'd3,   0);
        put_frame(1'b1, OP_TEXT,   1'b0, 64'd0,   0);
        put_frame(1'b1, OP_PING,   1'b1, 64'd0,   0);
        put_frame(1'b0, OP_PONG,   1'b0, 64'd2,   0);
        put_frame(1'b0, OP_TEXT,   1'b1, 64'd2,   1);
        put_frame(1'b1, OP_PING,   1'b0, 64'd1,   0);
        put_frame(1'b1, OP_BINARY, 1'b1, 64'd1,   0);
        put_frame(1'b0, OP_CONT,   1'b0, 64'd0,   0);
        put_frame(1'b1, OP_CONT,   1'b1, 64'd1,   2);
        put_frame(1'b1, OP_CONT,   1'b0, 64'd0,   0);
        put_frame(1'b0, OP_BINARY, 1'b0, 64'd0,   0);
        put_frame(1'b0, OP_TEXT,   1'b1, 64'd1,   0);
        put_frame(1'b1, OP_CONT,   1'b0, 64'd0,   1);
        put_frame(1'b1, OP_TEXT,   1'b1, 64'd125, 0);
        put_frame(1'b1, OP_BINARY, 1'b0, 64'd126, 1);
        wait_drained();

        apply_max_len(1'b1, 32'hFFFF_FFFF);
        random_traffic(450);
        wait_drained();

        // With a zero limit only empty frames get through.
        apply_max_len(1'b1, 32'd0);
        random_traffic(50);
        wait_drained();

        apply_max_len(1'b1, $urandom_range(1, 200));
        random_traffic(450);
        wait_drained();

        quiet = 1'b1;
        apply_max_len(1'b1, $urandom_range(126, 4000));
        random_traffic(200);

        // One frame that stops the parser for good, then ignored bytes.
        pick = $urandom_range(0, 5);
        case (pick)
            0: begin
                end_case = "an oversized length";
                opc = 4'($urandom_range(0, 15));
                case ($urandom_range(0, 2))
                    0:       big_len = {32'd0, p_max_len} + 64'd1;
                    1:       big_len = 64'h0000_0001_0000_0000;
                    default: big_len = 64'hFFFF_FFFF_FFFF_FFFF;
                endcase
                put_frame(1'($urandom_range(0, 1)), opc, 1'($urandom_range(0, 1)),
                          big_len, $urandom_range(0, 2));
            end
            1: begin
                end_case = "an invalid opcode";
                do opc = 4'($urandom_range(0, 15)); while (known_opcode(opc));
                put_frame(1'($urandom_range(0, 1)), opc, 1'($urandom_range(0, 1)),
                          frame_len(), $urandom_range(0, 2));
            end
            default: begin
                end_case = "a close frame";
                put_frame(1'($urandom_range(0, 1)), OP_CLOSE, 1'($urandom_range(0, 1)),
                          (pick < 5) ? 64'(pick - 2) : 64'($urandom_range(3, 20)),
                          $urandom_range(0, 2));
            end
        endcase
        repeat (16) push_byte(8'($urandom_range(0, 255)));
        wait_drained();
        repeat (8) @(negedge clk);

        if (frame_events_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", frame_events_q.size()));
        $display("Checked %0d results from %0d stream bytes in %0d frames, %0d limit settings.",
                 n_results, n_in_acc, n_frames, n_settings + 1);
        $display("The stream ended with %s; %0d mismatches.", end_case, n_err);
        if (n_err == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/wsfd_pkg.sv
src/wsfd_parser.sv
src/websocket_frame_deframer_top.sv
dv/tb_websocket_frame_deframer_top.sv
